// ===== rtl/scb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk boundary scanner package
// Shared types, character codes, register indexes and limits.
// ----------------------------------------------------------------------------
package scb_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXT_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_GAP = CSR_INDEX_BITS'(1);

   localparam logic [15:0] MIN_GAP_RESET = 16'd128;

   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_OPEN = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE = 8'h7D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   localparam logic signed [31:0] DEPTH_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [1:0] MARKER_TAIL = 2'd2;

   typedef struct packed {
      logic is_hash;
      logic is_break;
      logic is_open;
      logic is_close;
      logic marker_ahead;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/scb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk boundary scanner front end
// Accepts byte words, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module scb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_byte_value,
   input  wire logic [7:0]        req_next_byte,
   input  wire logic [7:0]        req_after_next_byte,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output scb_pkg::item_type      out_item
);
   import scb_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign req_ready = !valid_ff || out_ready;
   assign accept = req_valid && req_ready;
   assign valid_in = accept || (valid_ff && !out_ready);

   always_comb begin
      item_in.is_hash = (req_byte_value == CHAR_HASH);
      item_in.is_break = (req_byte_value == CHAR_LF) || (req_byte_value == CHAR_CR) ||
                         (req_byte_value == CHAR_FF);
      item_in.is_open = (req_byte_value == CHAR_OPEN);
      item_in.is_close = (req_byte_value == CHAR_CLOSE);
      item_in.marker_ahead = (req_next_byte == CHAR_HASH) &&
                             (req_after_next_byte == CHAR_HASH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule
`default_nettype wire

// ===== rtl/scb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk boundary scanner queue
// Short first-in first-out buffer of classified words between the two halves.
// ----------------------------------------------------------------------------
module scb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire scb_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output scb_pkg::item_type      out_item
);
   import scb_pkg::*;

   localparam int AddrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AddrBits-1:0] LastAddr = AddrBits'(QUEUE_DEPTH - 1);
   localparam logic [CountBits-1:0] FullCount = CountBits'(QUEUE_DEPTH);

   item_type             entries_ff [QUEUE_DEPTH];
   logic [AddrBits-1:0]  wr_ptr_ff;
   logic [AddrBits-1:0]  wr_ptr_in;
   logic [AddrBits-1:0]  rd_ptr_ff;
   logic [AddrBits-1:0]  rd_ptr_in;
   logic [CountBits-1:0] count_ff;
   logic [CountBits-1:0] count_in;
   logic                 push;
   logic                 pop;

   assign in_ready = (count_ff != FullCount);
   assign out_valid = (count_ff != '0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + AddrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + AddrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/scb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk boundary scanner back end
// Keeps the comment, brace and counter state, decides cuts, registers results.
// ----------------------------------------------------------------------------
module scb_back #(
   parameter int POSITION_BITS = scb_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire scb_pkg::item_type in_item,
   input  wire logic [31:0]       text_length,
   input  wire logic [15:0]       min_gap,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_cut_here,
   output logic [31:0]            rsp_lines_seen,
   output logic [31:0]            rsp_chunks_seen,
   output logic                   rsp_final_byte
);
   import scb_pkg::*;

   localparam int WideBits = (POSITION_BITS > 32) ? POSITION_BITS : 32;
   localparam int CmpBits = WideBits + 1;

   logic [POSITION_BITS-1:0] position_ff;
   logic [POSITION_BITS-1:0] position_in;
   logic [POSITION_BITS-1:0] chunk_start_ff;
   logic [POSITION_BITS-1:0] chunk_start_in;
   logic signed [31:0]       brace_depth_ff;
   logic signed [31:0]       brace_depth_in;
   logic                     prev_break_ff;
   logic                     prev_break_in;
   logic                     line_open_ff;
   logic                     line_open_in;
   logic                     block_open_ff;
   logic                     block_open_in;
   logic [1:0]               skip_ff;
   logic [1:0]               skip_in;
   logic [31:0]              line_total_ff;
   logic [31:0]              line_total_in;
   logic [31:0]              chunk_total_ff;
   logic [31:0]              chunk_total_in;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_cut_ff;
   logic [31:0]              rsp_lines_ff;
   logic [31:0]              rsp_chunks_ff;
   logic                     rsp_final_ff;

   logic                     take;
   logic                     cut;
   logic [POSITION_BITS-1:0] position_next;
   logic [CmpBits-1:0]       pos_x;
   logic [CmpBits-1:0]       start_x;
   logic [CmpBits-1:0]       length_x;
   logic [CmpBits-1:0]       gap_x;
   logic                     room_marker;
   logic                     long_enough;
   logic                     room_left;
   logic                     final_b;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take = in_valid && in_ready;

   assign pos_x = {{(CmpBits - POSITION_BITS){1'b0}}, position_ff};
   assign start_x = {{(CmpBits - POSITION_BITS){1'b0}}, chunk_start_ff};
   assign length_x = {{(CmpBits - 32){1'b0}}, text_length};
   assign gap_x = {{(CmpBits - 16){1'b0}}, min_gap};

   assign room_marker = (pos_x + CmpBits'(2)) < length_x;
   assign long_enough = pos_x > (start_x + gap_x);
   assign room_left = (pos_x + gap_x) < length_x;
   assign final_b = (text_length != '0) && (pos_x == (length_x - CmpBits'(1)));
   assign position_next = position_ff + POSITION_BITS'(1);

   always_comb begin
      position_in = position_ff;
      chunk_start_in = chunk_start_ff;
      brace_depth_in = brace_depth_ff;
      prev_break_in = prev_break_ff;
      line_open_in = line_open_ff;
      block_open_in = block_open_ff;
      skip_in = skip_ff;
      line_total_in = line_total_ff;
      chunk_total_in = chunk_total_ff;
      cut = 1'b0;
      if (take) begin
         prev_break_in = in_item.is_break;
         position_in = position_next;
         if (skip_ff != '0) begin
            skip_in = skip_ff - 2'd1;
         end else if (in_item.is_hash) begin
            if (!line_open_ff && room_marker && in_item.marker_ahead) begin
               block_open_in = !block_open_ff;
               skip_in = MARKER_TAIL;
            end else begin
               line_open_in = 1'b1;
            end
         end else if (in_item.is_break) begin
            if (line_total_ff != COUNT_MAX) begin
               line_total_in = line_total_ff + 32'd1;
            end
            line_open_in = 1'b0;
            if ((brace_depth_ff == '0) && !block_open_ff && prev_break_ff &&
                long_enough && room_left) begin
               cut = 1'b1;
               chunk_start_in = position_next;
               if (chunk_total_ff != COUNT_MAX) begin
                  chunk_total_in = chunk_total_ff + 32'd1;
               end
            end
         end else if (!line_open_ff && !block_open_ff) begin
            if (in_item.is_open && (brace_depth_ff != DEPTH_MAX)) begin
               brace_depth_in = brace_depth_ff + 32'sd1;
            end else if (in_item.is_close && (brace_depth_ff != DEPTH_MIN)) begin
               brace_depth_in = brace_depth_ff - 32'sd1;
            end
         end
      end
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         chunk_start_ff <= '0;
         brace_depth_ff <= '0;
         prev_break_ff <= 1'b0;
         line_open_ff <= 1'b0;
         block_open_ff <= 1'b0;
         skip_ff <= '0;
         line_total_ff <= '0;
         chunk_total_ff <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff <= position_in;
         chunk_start_ff <= chunk_start_in;
         brace_depth_ff <= brace_depth_in;
         prev_break_ff <= prev_break_in;
         line_open_ff <= line_open_in;
         block_open_ff <= block_open_in;
         skip_ff <= skip_in;
         line_total_ff <= line_total_in;
         chunk_total_ff <= chunk_total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_cut_ff <= cut;
         rsp_lines_ff <= line_total_in;
         rsp_chunks_ff <= chunk_total_in;
         rsp_final_ff <= final_b;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cut_here = rsp_cut_ff;
   assign rsp_lines_seen = rsp_lines_ff;
   assign rsp_chunks_seen = rsp_chunks_ff;
   assign rsp_final_byte = rsp_final_ff;

endmodule
`default_nettype wire

// ===== rtl/source_chunk_boundary_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Source chunk boundary scanner
// Scans text bytes with two lookahead bytes and marks line breaks that end a
// chunk, reporting running line and chunk counts for every byte.
//
// Usage:
// The request channel (req_) takes one word per text byte: the byte and the
// two bytes that follow it. The response channel (rsp_) returns one word per
// request word, in order. The csr_ channel writes text_length (index 0) and
// min_gap (index 1); it is always ready, and the user must write it only
// while idle, as the block does not enforce this. A response word passes
// through the front register, the queue and the back end's response register.
// Throughput is one byte per cycle while the receiver does not stall. A front
// register and a two-entry queue decouple the front end from the back end, so
// up to four words are absorbed while the receiver stalls before req_ready
// drops. Synchronous reset clears all scan state and counters (chunk count to
// one) and restores the default register values (text_length 0, min_gap 128).
// ----------------------------------------------------------------------------
module source_chunk_boundary_scanner #(
   parameter int POSITION_BITS = scb_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_byte_value,
   input  wire logic [7:0]                         req_next_byte,
   input  wire logic [7:0]                         req_after_next_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_cut_here,
   output logic [31:0]                             rsp_lines_seen,
   output logic [31:0]                             rsp_chunks_seen,
   output logic                                    rsp_final_byte,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [scb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [scb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import scb_pkg::*;

   logic [31:0] text_length_ff;
   logic [15:0] min_gap_ff;
   logic        csr_write;
   logic        front_valid;
   logic        front_ready;
   item_type    front_item;
   logic        q_valid;
   logic        q_ready;
   item_type    q_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_length_ff <= '0;
         min_gap_ff <= MIN_GAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TEXT_LENGTH: text_length_ff <= csr_wdata[31:0];
            CSR_MIN_GAP:     min_gap_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   scb_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_value      (req_byte_value),
      .req_next_byte       (req_next_byte),
      .req_after_next_byte (req_after_next_byte),
      .out_valid           (front_valid),
      .out_ready           (front_ready),
      .out_item            (front_item)
   );

   scb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   scb_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_item         (q_item),
      .text_length     (text_length_ff),
      .min_gap         (min_gap_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cut_here    (rsp_cut_here),
      .rsp_lines_seen  (rsp_lines_seen),
      .rsp_chunks_seen (rsp_chunks_seen),
      .rsp_final_byte  (rsp_final_byte)
   );

`ifndef SYNTHESIS
   a_take_gives_word: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> rsp_valid)
      else $error("back end took a word but no response followed");

   a_cut_counts_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cut_here) |-> (rsp_lines_seen != '0))
      else $error("cut reported with no line break counted");

   a_chunks_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chunks_seen != '0))
      else $error("chunk count dropped to zero");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/scb_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk boundary scanner scoreboard
// Keeps its own copy of the scan state and the two registers, predicts the
// response word for every accepted byte word and checks the response words
// in order against those predictions.
// ----------------------------------------------------------------------------
package scb_tb_pkg;
   import scb_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = CSR_INDEX_BITS'(9);

   typedef struct packed {
      logic        cut_here;
      logic [31:0] lines_seen;
      logic [31:0] chunks_seen;
      logic        final_byte;
   } scan_word_type;

   class chunk_scan_scoreboard;
      logic [31:0]        text_length;
      logic [15:0]        min_gap;
      logic [31:0]        position;
      logic [31:0]        chunk_base;
      logic signed [31:0] depth;
      logic [7:0]         prev_char;
      bit                 in_line_comment;
      bit                 in_block_comment;
      logic [1:0]         skip_left;
      logic [31:0]        line_count;
      logic [31:0]        chunk_count;
      scan_word_type      expected_words[$];
      int unsigned        bytes_noted;
      int unsigned        words_checked;
      int unsigned        cuts_predicted;
      int unsigned        mismatches;

      function new();
         text_length = '0;
         min_gap = MIN_GAP_RESET;
         position = '0;
         chunk_base = '0;
         depth = '0;
         prev_char = '0;
         in_line_comment = 1'b0;
         in_block_comment = 1'b0;
         skip_left = '0;
         line_count = '0;
         chunk_count = 32'd1;
         bytes_noted = 0;
         words_checked = 0;
         cuts_predicted = 0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index, logic [31:0] data);
         if (index == CSR_TEXT_LENGTH) begin
            text_length = data;
         end else if (index == CSR_MIN_GAP) begin
            min_gap = data[15:0];
         end
      endfunction

      function bit is_line_break(logic [7:0] ch);
         return ch == CHAR_LF || ch == CHAR_CR || ch == CHAR_FF;
      endfunction

      function void note_byte(logic [7:0] ch, logic [7:0] ahead1, logic [7:0] ahead2);
         scan_word_type w;
         logic [31:0]   idx;
         bit            room;
         bit            long_enough;
         bit            room_left;
         idx = position;
         w.cut_here = 1'b0;
         w.final_byte = (text_length != 0) && (idx == text_length - 32'd1);
         if (skip_left != 0) begin
            skip_left--;
         end else if (ch == CHAR_HASH) begin
            room = (idx < text_length) && (text_length - idx > 32'd2);
            if (!in_line_comment && room && ahead1 == CHAR_HASH && ahead2 == CHAR_HASH) begin
               in_block_comment = !in_block_comment;
               skip_left = MARKER_TAIL;
            end else begin
               in_line_comment = 1'b1;
            end
         end else if (is_line_break(ch)) begin
            if (line_count != COUNT_MAX) line_count++;
            in_line_comment = 1'b0;
            long_enough = (idx > chunk_base) && (idx - chunk_base > 32'(min_gap));
            room_left = (text_length > 32'(min_gap)) && (idx < text_length - 32'(min_gap));
            if (depth == 0 && !in_block_comment && is_line_break(prev_char)
                && long_enough && room_left) begin
               w.cut_here = 1'b1;
               chunk_base = idx + 32'd1;
               if (chunk_count != COUNT_MAX) chunk_count++;
               cuts_predicted++;
            end
         end else if (!in_line_comment && !in_block_comment) begin
            if (ch == CHAR_OPEN && depth != DEPTH_MAX) begin
               depth++;
            end else if (ch == CHAR_CLOSE && depth != DEPTH_MIN) begin
               depth--;
            end
         end
         prev_char = ch;
         position = idx + 32'd1;
         w.lines_seen = line_count;
         w.chunks_seen = chunk_count;
         expected_words.push_back(w);
         bytes_noted++;
      endfunction

      function void check_word(logic cut, logic [31:0] lines, logic [31:0] chunks, logic last);
         scan_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response word: cut %0b lines %0d chunks %0d final %0b",
                        cut, lines, chunks, last);
            return;
         end
         want = expected_words.pop_front();
         if (want.cut_here !== cut || want.lines_seen !== lines
             || want.chunks_seen !== chunks || want.final_byte !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch at word %0d: expected %0b %0d %0d %0b, got %0b %0d %0d %0b",
                        words_checked, want.cut_here, want.lines_seen, want.chunks_seen,
                        want.final_byte, cut, lines, chunks, last);
         end
         words_checked++;
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk boundary scanner testbench
// Drives a short directed byte sequence and then phases of generated source
// text under changing register settings, with random stalls on both channels,
// and checks every response word against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import scb_pkg::*;
   import scb_tb_pkg::*;

   localparam int unsigned ITEMS_TARGET = 1850;
   localparam int unsigned QUIET_FROM = 1500;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_byte_value;
   logic [7:0]                req_next_byte;
   logic [7:0]                req_after_next_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_cut_here;
   logic [31:0]               rsp_lines_seen;
   logic [31:0]               rsp_chunks_seen;
   logic                      rsp_final_byte;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   chunk_scan_scoreboard sb = new();
   logic [7:0]           phase_text[$];
   bit                   idle_on = 1'b1;
   bit                   hold_request = 1'b0;
   int unsigned          cycle_count = 0;
   int unsigned          settings_used = 0;

   source_chunk_boundary_scanner u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_value      (req_byte_value),
      .req_next_byte       (req_next_byte),
      .req_after_next_byte (req_after_next_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cut_here        (rsp_cut_here),
      .rsp_lines_seen      (rsp_lines_seen),
      .rsp_chunks_seen     (rsp_chunks_seen),
      .rsp_final_byte      (rsp_final_byte),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_cut_here, rsp_lines_seen, rsp_chunks_seen, rsp_final_byte);
   end

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic configure(input logic [31:0] text_len, input logic [31:0] gap_word,
                            input bit poke_unused);
      logic [CSR_INDEX_BITS-1:0] index_list[3];
      logic [31:0]               data_list[3];
      int                        k;
      index_list[0] = CSR_UNUSED;
      data_list[0] = $urandom;
      index_list[1] = CSR_TEXT_LENGTH;
      data_list[1] = text_len;
      index_list[2] = CSR_MIN_GAP;
      data_list[2] = gap_word;
      for (k = poke_unused ? 0 : 1; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[k];
         csr_wdata <= data_list[k];
         do @(posedge clock); while (!csr_ready);
         sb.write_register(index_list[k], data_list[k]);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (sb.expected_words.size() != 0) @(posedge clock);
   endtask

   // The last two bytes of phase_text only serve as lookahead.
   task automatic send_text(input bit noisy);
      int unsigned k;
      logic [7:0]  ahead1;
      logic [7:0]  ahead2;
      for (k = 0; k + 2 < phase_text.size(); k++) begin
         ahead1 = phase_text[k + 1];
         ahead2 = phase_text[k + 2];
         if (noisy && $urandom_range(0, 19) == 0) begin
            ahead1 = 8'($urandom);
            ahead2 = 8'($urandom);
         end
         if (idle_on && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_byte_value <= phase_text[k];
         req_next_byte <= ahead1;
         req_after_next_byte <= ahead2;
         do @(posedge clock); while (!req_ready);
         sb.note_byte(phase_text[k], ahead1, ahead2);
      end
      req_valid <= 1'b0;
   endtask

   // Builds source-like text: code, braces kept near balance, line and block
   // comments, paragraph breaks, and a share of arbitrary bytes.
   function automatic void compose_text(input int unsigned len);
      int unsigned pick;
      int          level;
      bit          in_block;
      phase_text.delete();
      level = sb.depth;
      in_block = sb.in_block_comment;
      while (phase_text.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            phase_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
         end else if (pick < 40) begin
            phase_text.push_back(CHAR_LF);
         end else if (pick < 46) begin
            phase_text.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_FF);
         end else if (pick < 55) begin
            if (level < 3) begin
               phase_text.push_back(CHAR_OPEN);
               if (!in_block) level++;
            end else begin
               phase_text.push_back(8'h78);
            end
         end else if (pick < 63) begin
            if (level > 0 || $urandom_range(0, 7) == 0) begin
               phase_text.push_back(CHAR_CLOSE);
               if (!in_block) level--;
            end else begin
               phase_text.push_back(8'h79);
            end
         end else if (pick < 71) begin
            phase_text.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 6)) phase_text.push_back(8'($urandom_range(32, 126)));
            phase_text.push_back(CHAR_LF);
         end else if (pick < 77) begin
            repeat (3) phase_text.push_back(CHAR_HASH);
            in_block = !in_block;
         end else if (pick < 90) begin
            repeat (2) phase_text.push_back($urandom_range(0, 3) == 0 ? CHAR_CR : CHAR_LF);
         end else begin
            phase_text.push_back(8'($urandom));
         end
      end
      while (phase_text.size() > len) void'(phase_text.pop_back());
      repeat (2) phase_text.push_back($urandom_range(0, 1) ? CHAR_HASH : 8'($urandom));
   endfunction

   initial begin
      int unsigned phase_no;
      int unsigned phase_len;
      logic [31:0] text_len;
      logic [31:0] gap_word;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_byte_value <= '0;
      req_next_byte <= '0;
      req_after_next_byte <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      configure(32'd23, 32'd0, 1'b1);
      phase_text = '{CHAR_OPEN, CHAR_LF, CHAR_LF, CHAR_CLOSE, CHAR_HASH, CHAR_OPEN,
                     CHAR_CR, CHAR_CR, CHAR_HASH, CHAR_HASH, CHAR_HASH, CHAR_OPEN,
                     CHAR_LF, CHAR_LF, CHAR_HASH, CHAR_HASH, CHAR_HASH, CHAR_FF,
                     CHAR_FF, 8'hFF, 8'h00, CHAR_HASH, CHAR_HASH, CHAR_HASH,
                     CHAR_LF, CHAR_LF, 8'h00, 8'h00};
      send_text(1'b0);

      phase_no = 1;
      while (sb.bytes_noted < ITEMS_TARGET) begin
         wait_drained();
         if (sb.bytes_noted >= QUIET_FROM) idle_on = 1'b0;
         phase_len = $urandom_range(20, 120);
         gap_word = $urandom;
         case (phase_no)
            1: begin
               text_len = '0;
               gap_word[15:0] = 16'd0;
            end
            2: begin
               text_len = 32'hFFFF_FFFF;
               gap_word[15:0] = 16'd0;
            end
            3: begin
               text_len = 32'hFFFF_FFFF;
               gap_word[15:0] = 16'd2;
               phase_len = 100;
            end
            4: begin
               text_len = 32'hFFFF_FFFF;
               gap_word[15:0] = 16'hFFFF;
            end
            default: begin
               text_len = sb.position + phase_len;
               if ($urandom_range(0, 3) == 0) text_len = text_len - $urandom_range(1, 4);
               case ($urandom_range(0, 9))
                  0, 1, 2: gap_word[15:0] = 16'($urandom_range(0, 3));
                  3, 4, 5, 6, 7: gap_word[15:0] = 16'($urandom_range(4, 24));
                  default: gap_word[15:0] = 16'($urandom_range(25, 60));
               endcase
            end
         endcase
         configure(text_len, gap_word, phase_no == 7);
         if (phase_no == 3) hold_request = 1'b1;
         compose_text(phase_len);
         send_text(1'b1);
         phase_no++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Scanned %0d bytes under %0d register settings; %0d responses checked.",
               sb.bytes_noted, settings_used, sb.words_checked);
      $display("Predicted %0d chunk cuts and %0d line breaks; %0d mismatches.",
               sb.cuts_predicted, sb.line_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
